>>> design/scip_pkg.sv
// Shared types and constants of the sorted curve interpolator.
package scip_pkg;

	localparam int TIME_W    = 24;
	localparam int RATE_W    = 32;
	localparam int OP_W      = 2;
	localparam int PIDX_W    = 6;
	localparam int DRATE_W   = RATE_W + 1;
	localparam int DTIME_W   = TIME_W + 1;
	localparam int PROD_W    = DRATE_W + DTIME_W;
	localparam int DIV_CNT_W = 6;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT  = 2'd0,
		OP_LOOKUP  = 2'd1,
		OP_FORWARD = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		RES_COUNT,
		RES_ZERO,
		RES_RATE,
		RES_INTERP,
		RES_FWD
	} res_sel_t;

	typedef enum logic [1:0] {
		RD_IDX,
		RD_KM1,
		RD_FPREV,
		RD_FCUR
	} rd_src_t;

	typedef enum logic [1:0] {
		WR_SHIFT,
		WR_NEW,
		WR_UPD
	} wr_src_t;

	typedef enum logic [1:0] {
		MUL_INTERP,
		MUL_CUR,
		MUL_PREV
	} mul_sel_t;

	typedef struct packed {
		logic     latch_in;
		logic     rd_en;
		rd_src_t  rd_src;
		logic     wr_en;
		wr_src_t  wr_src;
		logic     adv;
		logic     keep_prev;
		logic     pos_idx;
		logic     pos_cnt;
		logic     k_load;
		logic     k_dec;
		logic     cnt_inc;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     div_start;
		logic     div_fwd;
		logic     res_load;
		res_sel_t res_sel;
		status_t  res_status;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic cnt_zero;
		logic full;
		logic hit;
		logic eq;
		logic last;
		logic idx_zero;
		logic fidx_zero;
		logic fidx_oor;
		logic shift_done;
		logic div_done;
	} stat_t;

endpackage

>>> design/scip_if.sv
// Request and response channel interfaces of the sorted curve interpolator.
interface scip_req_if;
	logic                                  valid;
	logic                                  ready;
	logic [scip_pkg::OP_W-1:0]             op;
	logic [scip_pkg::TIME_W-1:0]           time_point;
	logic signed [scip_pkg::RATE_W-1:0]    rate_value;
	logic [scip_pkg::PIDX_W-1:0]           pillar_index;

	modport source (output valid, op, time_point, rate_value, pillar_index, input ready);
	modport sink (input valid, op, time_point, rate_value, pillar_index, output ready);
endinterface

interface scip_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [scip_pkg::RATE_W-1:0]    result_value;
	logic [1:0]                            status;
	logic                                  saturated;

	modport source (output valid, result_value, status, saturated, input ready);
	modport sink (input valid, result_value, status, saturated, output ready);
endinterface

>>> design/scip_div.sv
// Restoring signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
module scip_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [scip_pkg::PROD_W-1:0]    num,
	input  logic [scip_pkg::TIME_W-1:0]           den,
	output logic                                  done,
	output logic signed [scip_pkg::PROD_W-1:0]    quo
);
	localparam int PW = scip_pkg::PROD_W;
	localparam int TW = scip_pkg::TIME_W;
	localparam int CW = scip_pkg::DIV_CNT_W;

	logic [PW-1:0] mag_q;
	logic [TW:0]   rem_q;
	logic [TW-1:0] den_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [TW:0]   rem_sh;
	logic          ge;

	assign rem_sh = {rem_q[TW-1:0], mag_q[PW-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(PW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[PW-1];
			mag_q <= num[PW-1] ? PW'(-num) : PW'(num);
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
			mag_q <= {mag_q[PW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -$signed(mag_q) : $signed(mag_q);
endmodule

>>> design/scip_dp.sv
// Datapath: pillar memories, scan counters, shared multiplier, divider and result register.
module scip_dp #(
	parameter int MAX_PILLARS = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  scip_pkg::cmd_t                       cmd,
	output scip_pkg::stat_t                      stat,
	input  logic [scip_pkg::OP_W-1:0]            op,
	input  logic [scip_pkg::TIME_W-1:0]          time_point,
	input  logic signed [scip_pkg::RATE_W-1:0]   rate_value,
	input  logic [scip_pkg::PIDX_W-1:0]          pillar_index,
	output logic signed [scip_pkg::RATE_W-1:0]   result_value,
	output logic [1:0]                           status,
	output logic                                 saturated
);
	localparam int TW = scip_pkg::TIME_W;
	localparam int RW = scip_pkg::RATE_W;
	localparam int PW = scip_pkg::PROD_W;
	localparam int AW = $clog2(MAX_PILLARS);
	localparam int CW = $clog2(MAX_PILLARS + 1);
	localparam int IW = (CW > scip_pkg::PIDX_W) ? CW : scip_pkg::PIDX_W;

	logic [TW-1:0]        times_mem [MAX_PILLARS];
	logic signed [RW-1:0] rates_mem [MAX_PILLARS];

	scip_pkg::op_t        op_q;
	logic [TW-1:0]        t_q;
	logic signed [RW-1:0] r_q;
	logic [scip_pkg::PIDX_W-1:0] pidx_q;
	logic [CW-1:0]        cnt_q, idx_q, k_q, pos_q;
	logic [TW-1:0]        rd_t_q, prev_t_q;
	logic signed [RW-1:0] rd_r_q, prev_r_q;
	logic signed [PW-1:0] prod_q, acc_q;
	logic signed [RW-1:0] res_q;
	logic [1:0]           stat_q;
	logic                 sat_q;

	logic [IW-1:0]        pidx_ext, cnt_ext, fprev_ext;
	logic [CW-1:0]        km1;
	logic [AW-1:0]        rd_addr, wr_addr;
	logic signed [scip_pkg::DRATE_W-1:0] mul_a;
	logic signed [scip_pkg::DTIME_W-1:0] mul_b;
	logic signed [PW-1:0] prod_c, div_num, quo;
	logic                 div_done;
	logic                 sat_hi, sat_lo;
	logic signed [RW-1:0] fwd_val, interp_val;

	assign pidx_ext  = IW'(pidx_q);
	assign cnt_ext   = IW'(cnt_q);
	assign fprev_ext = pidx_ext - IW'(1);
	assign km1       = k_q - CW'(1);

	always_comb begin
		unique case (cmd.rd_src)
			scip_pkg::RD_IDX:   rd_addr = idx_q[AW-1:0];
			scip_pkg::RD_KM1:   rd_addr = km1[AW-1:0];
			scip_pkg::RD_FPREV: rd_addr = fprev_ext[AW-1:0];
			default:            rd_addr = pidx_ext[AW-1:0];
		endcase
	end

	always_comb begin
		unique case (cmd.wr_src)
			scip_pkg::WR_SHIFT: wr_addr = k_q[AW-1:0];
			scip_pkg::WR_NEW:   wr_addr = pos_q[AW-1:0];
			default:            wr_addr = idx_q[AW-1:0];
		endcase
	end

	// Shifting copies the entry just read one place up.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			unique case (cmd.wr_src)
				scip_pkg::WR_SHIFT: begin
					times_mem[wr_addr] <= rd_t_q;
					rates_mem[wr_addr] <= rd_r_q;
				end
				scip_pkg::WR_NEW: begin
					times_mem[wr_addr] <= t_q;
					rates_mem[wr_addr] <= r_q;
				end
				default: rates_mem[wr_addr] <= r_q;
			endcase
		end
		if (cmd.rd_en) begin
			rd_t_q <= times_mem[rd_addr];
			rd_r_q <= rates_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
			k_q   <= '0;
			pos_q <= '0;
		end else begin
			if (cmd.latch_in) begin
				idx_q <= '0;
			end else if (cmd.adv) begin
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.k_load) begin
				k_q <= cnt_q;
			end else if (cmd.k_dec) begin
				k_q <= km1;
			end
			if (cmd.pos_idx) begin
				pos_q <= idx_q;
			end else if (cmd.pos_cnt) begin
				pos_q <= cnt_q;
			end
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q   <= scip_pkg::op_t'(op);
			t_q    <= time_point;
			r_q    <= rate_value;
			pidx_q <= pillar_index;
		end
		if (cmd.adv || cmd.keep_prev) begin
			prev_t_q <= rd_t_q;
			prev_r_q <= rd_r_q;
		end
		if (cmd.mul_en) begin
			prod_q <= prod_c;
			acc_q  <= prod_q;
		end
	end

	always_comb begin
		unique case (cmd.mul_sel)
			scip_pkg::MUL_INTERP: begin
				mul_a = scip_pkg::DRATE_W'(rd_r_q) - scip_pkg::DRATE_W'(prev_r_q);
				mul_b = $signed({1'b0, t_q}) - $signed({1'b0, prev_t_q});
			end
			scip_pkg::MUL_CUR: begin
				mul_a = scip_pkg::DRATE_W'(rd_r_q);
				mul_b = $signed({1'b0, rd_t_q});
			end
			default: begin
				mul_a = scip_pkg::DRATE_W'(prev_r_q);
				mul_b = $signed({1'b0, prev_t_q});
			end
		endcase
	end

	assign prod_c  = mul_a * mul_b;
	assign div_num = cmd.div_fwd ? acc_q - prod_q : prod_q;

	scip_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (rd_t_q - prev_t_q),
		.done   (div_done),
		.quo    (quo)
	);

	assign sat_hi     = !quo[PW-1] && (quo[PW-2:RW-1] != '0);
	assign sat_lo     = quo[PW-1] && (quo[PW-2:RW-1] != '1);
	assign interp_val = prev_r_q + $signed(quo[RW-1:0]);

	always_comb begin
		priority if (sat_hi) begin
			fwd_val = $signed({1'b0, {(RW-1){1'b1}}});
		end else if (sat_lo) begin
			fwd_val = $signed({1'b1, {(RW-1){1'b0}}});
		end else begin
			fwd_val = $signed(quo[RW-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			stat_q <= cmd.res_status;
			sat_q  <= 1'b0;
			unique case (cmd.res_sel)
				scip_pkg::RES_COUNT:  res_q <= RW'(cnt_q);
				scip_pkg::RES_RATE:   res_q <= rd_r_q;
				scip_pkg::RES_INTERP: res_q <= interp_val;
				scip_pkg::RES_FWD: begin
					res_q <= fwd_val;
					sat_q <= sat_hi || sat_lo;
				end
				default: res_q <= '0;
			endcase
		end
	end

	assign result_value = res_q;
	assign status       = stat_q;
	assign saturated    = sat_q;

	always_comb begin
		stat.op         = op_q;
		stat.cnt_zero   = cnt_q == '0;
		stat.full       = cnt_q == CW'(MAX_PILLARS);
		stat.hit        = t_q <= rd_t_q;
		stat.eq         = t_q == rd_t_q;
		stat.last       = idx_q == cnt_q - CW'(1);
		stat.idx_zero   = idx_q == '0;
		stat.fidx_zero  = pidx_q == '0;
		stat.fidx_oor   = pidx_ext >= cnt_ext;
		stat.shift_done = k_q == pos_q;
		stat.div_done   = div_done;
	end
endmodule

>>> design/scip_ctrl.sv
// Controller state machine: sequences scans, shifts, multiplies, divides and result hand-off.
module scip_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	input  scip_pkg::stat_t  stat,
	output scip_pkg::cmd_t   cmd
);
	typedef enum logic [15:0] {
		S_IDLE     = 16'h0001,
		S_DISPATCH = 16'h0002,
		S_SCAN_RD  = 16'h0004,
		S_SCAN_CMP = 16'h0008,
		S_SH_RD    = 16'h0010,
		S_SH_WR    = 16'h0020,
		S_INS_WR   = 16'h0040,
		S_FW_RD0   = 16'h0080,
		S_FW_RD1   = 16'h0100,
		S_FW_CAP   = 16'h0200,
		S_MUL_F1   = 16'h0400,
		S_MUL_F2   = 16'h0800,
		S_MUL_LK   = 16'h1000,
		S_DIV_GO   = 16'h2000,
		S_DIV_WAIT = 16'h4000,
		S_RESULT   = 16'h8000
	} state_t;

	state_t               state_q, state_d;
	scip_pkg::res_sel_t   sel_q, sel_d;
	scip_pkg::status_t    st_q, st_d;
	logic                 ovalid_q;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		sel_d     = sel_q;
		st_d      = st_q;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (stat.op)
					scip_pkg::OP_INSERT: begin
						if (stat.cnt_zero) begin
							cmd.pos_cnt = 1'b1;
							cmd.k_load  = 1'b1;
							state_d     = S_SH_RD;
						end else begin
							state_d = S_SCAN_RD;
						end
					end
					scip_pkg::OP_LOOKUP: begin
						if (stat.cnt_zero) begin
							sel_d   = scip_pkg::RES_ZERO;
							st_d    = scip_pkg::ST_EMPTY;
							state_d = S_RESULT;
						end else begin
							state_d = S_SCAN_RD;
						end
					end
					scip_pkg::OP_FORWARD: begin
						priority if (stat.cnt_zero) begin
							sel_d   = scip_pkg::RES_ZERO;
							st_d    = scip_pkg::ST_EMPTY;
							state_d = S_RESULT;
						end else if (stat.fidx_oor) begin
							sel_d   = scip_pkg::RES_ZERO;
							st_d    = scip_pkg::ST_RANGE;
							state_d = S_RESULT;
						end else if (stat.fidx_zero) begin
							state_d = S_FW_RD1;
						end else begin
							state_d = S_FW_RD0;
						end
					end
					default: begin
						sel_d   = scip_pkg::RES_COUNT;
						st_d    = scip_pkg::ST_OK;
						state_d = S_RESULT;
					end
				endcase
			end
			S_SCAN_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_src = scip_pkg::RD_IDX;
				state_d    = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				if (stat.op == scip_pkg::OP_INSERT) begin
					priority if (stat.hit && stat.eq) begin
						cmd.wr_en  = 1'b1;
						cmd.wr_src = scip_pkg::WR_UPD;
						sel_d      = scip_pkg::RES_COUNT;
						st_d       = scip_pkg::ST_OK;
						state_d    = S_RESULT;
					end else if (stat.hit || stat.last) begin
						cmd.pos_idx = stat.hit;
						cmd.pos_cnt = !stat.hit;
						if (stat.full) begin
							sel_d   = scip_pkg::RES_COUNT;
							st_d    = scip_pkg::ST_FULL;
							state_d = S_RESULT;
						end else begin
							cmd.k_load = 1'b1;
							state_d    = S_SH_RD;
						end
					end else begin
						cmd.adv = 1'b1;
						state_d = S_SCAN_RD;
					end
				end else begin
					// Below the first pillar or past the last one the edge rate is returned.
					priority if (stat.hit && !stat.idx_zero) begin
						state_d = S_MUL_LK;
					end else if (stat.hit || stat.last) begin
						sel_d   = scip_pkg::RES_RATE;
						st_d    = scip_pkg::ST_OK;
						state_d = S_RESULT;
					end else begin
						cmd.adv = 1'b1;
						state_d = S_SCAN_RD;
					end
				end
			end
			S_SH_RD: begin
				if (stat.shift_done) begin
					state_d = S_INS_WR;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_src = scip_pkg::RD_KM1;
					state_d    = S_SH_WR;
				end
			end
			S_SH_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_src = scip_pkg::WR_SHIFT;
				cmd.k_dec  = 1'b1;
				state_d    = S_SH_RD;
			end
			S_INS_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_src  = scip_pkg::WR_NEW;
				cmd.cnt_inc = 1'b1;
				sel_d       = scip_pkg::RES_COUNT;
				st_d        = scip_pkg::ST_OK;
				state_d     = S_RESULT;
			end
			S_FW_RD0: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_src = scip_pkg::RD_FPREV;
				state_d    = S_FW_RD1;
			end
			S_FW_RD1: begin
				cmd.keep_prev = 1'b1;
				cmd.rd_en     = 1'b1;
				cmd.rd_src    = scip_pkg::RD_FCUR;
				state_d       = S_FW_CAP;
			end
			S_FW_CAP: begin
				if (stat.fidx_zero) begin
					sel_d   = scip_pkg::RES_RATE;
					st_d    = scip_pkg::ST_OK;
					state_d = S_RESULT;
				end else begin
					state_d = S_MUL_F1;
				end
			end
			S_MUL_F1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = scip_pkg::MUL_CUR;
				state_d     = S_MUL_F2;
			end
			S_MUL_F2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = scip_pkg::MUL_PREV;
				state_d     = S_DIV_GO;
			end
			S_MUL_LK: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = scip_pkg::MUL_INTERP;
				state_d     = S_DIV_GO;
			end
			S_DIV_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_fwd   = stat.op == scip_pkg::OP_FORWARD;
				state_d       = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (stat.div_done) begin
					sel_d   = (stat.op == scip_pkg::OP_FORWARD) ?
						scip_pkg::RES_FWD : scip_pkg::RES_INTERP;
					st_d    = scip_pkg::ST_OK;
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (!ovalid_q || rsp_ready) begin
					cmd.res_load   = 1'b1;
					cmd.res_sel    = sel_q;
					cmd.res_status = st_q;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			sel_q    <= scip_pkg::RES_ZERO;
			st_q     <= scip_pkg::ST_OK;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			st_q    <= st_d;
			if (cmd.res_load) begin
				ovalid_q <= 1'b1;
			end else if (rsp_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = ovalid_q;
endmodule

>>> design/sorted_curve_interpolator_top.sv
// Insert time grows with the pillars scanned and with the pillars shifted;
// lookup time grows with the pillars scanned and, when it interpolates, includes the divider;
// a forward rate that divides spends most of its time in the one-bit-per-cycle divider.
// One item is worked at a time; the next is taken while the last beat waits in the output register.
// Reset clears the pillar count and the controller; table contents stay undefined until written.
module sorted_curve_interpolator_top #(
	parameter int MAX_PILLARS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	scip_req_if.sink        req,
	scip_rsp_if.source      rsp
);
	scip_pkg::cmd_t  cmd;
	scip_pkg::stat_t stat;

	scip_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	scip_dp #(
		.MAX_PILLARS (MAX_PILLARS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.op           (req.op),
		.time_point   (req.time_point),
		.rate_value   (req.rate_value),
		.pillar_index (req.pillar_index),
		.result_value (rsp.result_value),
		.status       (rsp.status),
		.saturated    (rsp.saturated)
	);
endmodule

>>> design/scip_chk.sv
// Port-level checker of the sorted curve interpolator and its bind.
module scip_chk #(
	parameter int MAX_PILLARS = 64
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                req_valid,
	input logic                                req_ready,
	input logic                                rsp_valid,
	input logic                                rsp_ready,
	input logic signed [scip_pkg::RATE_W-1:0]  result_value,
	input logic [1:0]                          status,
	input logic                                saturated
);
	logic [1:0] pend_q;
	logic       req_fire, rsp_fire;

	assign req_fire = req_valid && req_ready;
	assign rsp_fire = rsp_valid && rsp_ready;

	// Items accepted whose beat has not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(req_fire) - 2'(rsp_fire);
		end
	end

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("response beat without an accepted item");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two items outstanding");

	a_sat_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && saturated |-> status == scip_pkg::ST_OK)
		else $error("saturated flag with error status");

	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == scip_pkg::ST_FULL |->
		result_value == scip_pkg::RATE_W'(MAX_PILLARS))
		else $error("full status without full count");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_value))
		else $error("stalled response beat changed");
endmodule

bind sorted_curve_interpolator_top scip_chk #(
	.MAX_PILLARS (MAX_PILLARS)
) u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.result_value (rsp.result_value),
	.status       (rsp.status),
	.saturated    (rsp.saturated)
);
